>>> hw/rtl/point_lens_warp_address_top_macros.svh
// Assertion macros used by the point lens warp address top level
`ifndef POINT_LENS_WARP_ADDRESS_TOP_MACROS_SVH
`define POINT_LENS_WARP_ADDRESS_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define PLW_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define PLW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

>>> hw/rtl/plw_pkg.sv
// Package: constants and types of the point lens warp address block
package plw_pkg;

    localparam int IMAGE_SIZE = 512;
    localparam int HALF       = IMAGE_SIZE / 2;

    localparam int COORD_W = 9;    // row and column fields
    localparam int LENS_W  = 11;   // lens offset register
    localparam int EIN_W   = 9;    // Einstein radius register
    localparam int CFG_W   = 11;   // configuration write data

    // divider widths: dividend, divisor and quotient
    localparam int DEND_W     = 44;
    localparam int DVS_W      = 30;
    localparam int DIV_STAGES = DEND_W;

    localparam int FRONT_STAGES = 7;
    localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + 1;

    // configuration register indexes
    localparam logic REG_LENS_OFFSET = 1'b0;
    localparam logic REG_EINSTEIN    = 1'b1;

    // operands handed from the arithmetic front to the dividers
    typedef struct packed {
        logic              valid;
        logic              bad;
        logic              neg_x;
        logic              neg_y;
        logic [DEND_W-1:0] dend_x;
        logic [DVS_W-1:0]  dvs_x;
        logic [DEND_W-1:0] dend_y;
        logic [DVS_W-1:0]  dvs_y;
    } front_out_t;

    // sideband carried alongside the divider pipeline
    typedef struct packed {
        logic bad;
        logic neg_x;
        logic neg_y;
    } side_t;

endpackage

>>> hw/rtl/plw_front.sv
// Arithmetic front: coordinates, products and rounded-division operands
module plw_front
    import plw_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [COORD_W-1:0]       out_row,
    input  logic [COORD_W-1:0]       out_col,
    input  logic signed [LENS_W-1:0] lens_offset,
    input  logic [EIN_W-1:0]         einstein_radius,
    output front_out_t               front_out
);

    // stage 1: centred coordinates and E squared
    logic               v1_reg, bad1_reg;
    logic signed [12:0] x1_reg;
    logic signed [10:0] y1_reg, xr1_reg;
    logic [17:0]        e2_1_reg;

    // stage 2: squares and R*x
    logic               v2_reg, bad2_reg;
    logic signed [12:0] x2_reg;
    logic signed [10:0] y2_reg;
    logic [17:0]        e2_2_reg;
    logic [21:0]        xx2_reg;
    logic [17:0]        yy2_reg, xrxr2_reg;
    logic signed [24:0] rx2_reg;

    // stage 3: D and the x numerator core
    logic               v3_reg, bad3_reg;
    logic signed [12:0] x3_reg;
    logic signed [10:0] y3_reg;
    logic [17:0]        e2_3_reg;
    logic [18:0]        d3_reg;
    logic signed [25:0] n3_reg;

    // stage 4: R*D, E^2*N and D-E^2
    logic               v4_reg, bad4_reg;
    logic signed [12:0] x4_reg;
    logic signed [10:0] y4_reg;
    logic [18:0]        d4_reg;
    logic signed [30:0] q4_reg;
    logic signed [44:0] en4_reg;
    logic signed [19:0] de4_reg;

    // stage 5: x*q and y*(D-E^2)
    logic               v5_reg, bad5_reg;
    logic [18:0]        d5_reg;
    logic signed [30:0] q5_reg;
    logic signed [44:0] en5_reg;
    logic signed [44:0] xq5_reg;
    logic signed [31:0] yde5_reg;

    // stage 6: full numerators
    logic               v6_reg, bad6_reg;
    logic [18:0]        d6_reg;
    logic signed [30:0] q6_reg;
    logic signed [45:0] numx6_reg;
    logic signed [31:0] numy6_reg;

    // stage 7: divider operands
    front_out_t f7_reg, f7_next;

    logic [45:0] abs_numx;
    logic [31:0] abs_numy;
    logic [30:0] abs_q;

    // hold valid bits under reset
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // advance the payload through stages 1 to 6
    always_ff @(posedge clk) begin
        bad1_reg <= (32'(out_row) >= IMAGE_SIZE) || (32'(out_col) >= IMAGE_SIZE)
                    || (lens_offset == '0);
        x1_reg   <= 13'($signed({4'b0, out_col})) - 13'(HALF) - 13'(lens_offset);
        y1_reg   <= 11'(HALF) - 11'($signed({2'b0, out_row}));
        xr1_reg  <= 11'($signed({2'b0, out_col})) - 11'(HALF);
        e2_1_reg <= 18'(einstein_radius * einstein_radius);

        bad2_reg  <= bad1_reg;
        x2_reg    <= x1_reg;
        y2_reg    <= y1_reg;
        e2_2_reg  <= e2_1_reg;
        xx2_reg   <= 22'(x1_reg * x1_reg);
        yy2_reg   <= 18'(y1_reg * y1_reg);
        xrxr2_reg <= 18'(xr1_reg * xr1_reg);
        rx2_reg   <= 25'(lens_offset * x1_reg);

        bad3_reg <= bad2_reg;
        x3_reg   <= x2_reg;
        y3_reg   <= y2_reg;
        e2_3_reg <= e2_2_reg;
        d3_reg   <= 19'(xrxr2_reg) + 19'(yy2_reg);
        n3_reg   <= $signed(26'(xx2_reg)) + $signed(26'(yy2_reg)) + 26'(rx2_reg);

        bad4_reg <= bad3_reg || (d3_reg == '0);
        x4_reg   <= x3_reg;
        y4_reg   <= y3_reg;
        d4_reg   <= d3_reg;
        q4_reg   <= 31'(lens_offset * $signed({1'b0, d3_reg}));
        en4_reg  <= 45'($signed({1'b0, e2_3_reg}) * n3_reg);
        de4_reg  <= $signed({1'b0, d3_reg}) - $signed({2'b0, e2_3_reg});

        bad5_reg <= bad4_reg;
        d5_reg   <= d4_reg;
        q5_reg   <= q4_reg;
        en5_reg  <= en4_reg;
        xq5_reg  <= 45'(x4_reg * q4_reg);
        yde5_reg <= 32'(y4_reg * de4_reg);

        bad6_reg  <= bad5_reg;
        d6_reg    <= d5_reg;
        q6_reg    <= q5_reg;
        numx6_reg <= 46'(xq5_reg) + 46'(en5_reg);
        numy6_reg <= yde5_reg;
    end

    // form 2|n|+|d| over 2|d| for rounding half away from zero
    always_comb begin
        abs_numx = numx6_reg[45] ? 46'(-numx6_reg) : 46'(numx6_reg);
        abs_numy = numy6_reg[31] ? 32'(-numy6_reg) : 32'(numy6_reg);
        abs_q    = q6_reg[30] ? 31'(-q6_reg) : 31'(q6_reg);

        f7_next.valid  = v6_reg;
        f7_next.bad    = bad6_reg;
        f7_next.neg_x  = numx6_reg[45] ^ q6_reg[30];
        f7_next.neg_y  = numy6_reg[31];
        f7_next.dend_x = DEND_W'({abs_numx, 1'b0}) + DEND_W'(abs_q);
        f7_next.dvs_x  = DVS_W'({abs_q, 1'b0});
        f7_next.dend_y = DEND_W'({abs_numy, 1'b0}) + DEND_W'(d6_reg);
        f7_next.dvs_y  = DVS_W'({d6_reg, 1'b0});
    end

    // hold the operand stage
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            f7_reg <= '0;
        end
        else begin
            f7_reg <= f7_next;
        end
    end

    assign front_out = f7_reg;

endmodule

>>> hw/rtl/plw_div.sv
// Pipelined restoring divider, one quotient bit per stage
module plw_div
    import plw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [DEND_W-1:0] dividend,
    input  logic [DVS_W-1:0]  divisor,
    output logic              out_valid,
    output logic [DEND_W-1:0] quotient
);

    logic              v_reg    [DIV_STAGES];
    logic [DVS_W-1:0]  rem_reg  [DIV_STAGES];
    logic [DEND_W-1:0] work_reg [DIV_STAGES];
    logic [DVS_W-1:0]  dvs_reg  [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic              v_in;
        logic [DVS_W-1:0]  rem_in;
        logic [DEND_W-1:0] work_in;
        logic [DVS_W-1:0]  dvs_in;
        logic [DVS_W:0]    trial;
        logic [DVS_W+1:0]  diff;
        logic              ge;

        if (s == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign work_in = dividend;
            assign dvs_in  = divisor;
        end
        else begin : g_rest
            assign v_in    = v_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign work_in = work_reg[s-1];
            assign dvs_in  = dvs_reg[s-1];
        end

        // shift in one dividend bit and try the subtraction
        always_comb begin
            trial = {rem_in, work_in[DEND_W-1]};
            diff  = {1'b0, trial} - {2'b0, dvs_in};
            ge    = ~diff[DVS_W+1];
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                v_reg[s] <= 1'b0;
            end
            else begin
                v_reg[s] <= v_in;
            end
        end

        // advance remainder, shifting quotient bits in from the bottom
        always_ff @(posedge clk) begin
            rem_reg[s]  <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            work_reg[s] <= {work_in[DEND_W-2:0], ge};
            dvs_reg[s]  <= dvs_in;
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign quotient  = work_reg[DIV_STAGES-1];

endmodule

>>> hw/rtl/point_lens_warp_address_top.sv
// Top level of the point lens warp address generator
//
// Maps each destination pixel (out_row, out_col) to the source pixel that a
// point-mass lens images onto it. One pixel is taken every clock; busy is
// always low, since nothing can hold the pipeline. Each result appears on
// done, src_valid, src_row and src_col after passing, in order, through
// seven arithmetic stages, one stage per quotient bit in the two 44-bit
// dividers, and an output register. The receiver must take
// every result in the cycle it appears. Write the lens registers only while
// no pixel is in flight; cfg_ready is always high.
module point_lens_warp_address_top
    import plw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [COORD_W-1:0] out_row,
    input  logic [COORD_W-1:0] out_col,
    output logic               done,
    output logic               src_valid,
    output logic [COORD_W-1:0] src_row,
    output logic [COORD_W-1:0] src_col,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

`include "point_lens_warp_address_top_macros.svh"

    logic signed [LENS_W-1:0] lens_offset_reg;
    logic [EIN_W-1:0]         einstein_radius_reg;

    front_out_t        front;
    logic              divx_valid, divy_valid;
    logic [DEND_W-1:0] qx, qy;

    side_t side_reg [DIV_STAGES];

    logic signed [DEND_W+1:0] sx, sy, col_full, row_full;
    logic                     in_img;

    logic               done_reg, valid_reg;
    logic [COORD_W-1:0] row_reg, col_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration register transactions
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            lens_offset_reg     <= LENS_W'(1);
            einstein_radius_reg <= EIN_W'(1);
        end
        else if (cfg_valid) begin
            case (cfg_index)
                REG_LENS_OFFSET: lens_offset_reg     <= $signed(cfg_data[LENS_W-1:0]);
                REG_EINSTEIN:    einstein_radius_reg <= cfg_data[EIN_W-1:0];
                default: ;
            endcase
        end
    end

    plw_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (start),
        .out_row         (out_row),
        .out_col         (out_col),
        .lens_offset     (lens_offset_reg),
        .einstein_radius (einstein_radius_reg),
        .front_out       (front)
    );

    plw_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front.valid),
        .dividend  (front.dend_x),
        .divisor   (front.dvs_x),
        .out_valid (divx_valid),
        .quotient  (qx)
    );

    plw_div u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front.valid),
        .dividend  (front.dend_y),
        .divisor   (front.dvs_y),
        .out_valid (divy_valid),
        .quotient  (qy)
    );

    // carry flags and signs alongside the dividers
    always_ff @(posedge clk) begin
        side_reg[0] <= '{bad: front.bad, neg_x: front.neg_x, neg_y: front.neg_y};
        for (int i = 1; i < DIV_STAGES; i++) begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // apply signs, form the source address and check it lies in the image
    always_comb begin
        sx = side_reg[DIV_STAGES-1].neg_x ? -$signed({2'b0, qx}) : $signed({2'b0, qx});
        sy = side_reg[DIV_STAGES-1].neg_y ? -$signed({2'b0, qy}) : $signed({2'b0, qy});
        col_full = (DEND_W+2)'(HALF) + (DEND_W+2)'(lens_offset_reg) + sx;
        row_full = (DEND_W+2)'(HALF) - sy;
        in_img = !side_reg[DIV_STAGES-1].bad
                 && (col_full >= 0) && (col_full < (DEND_W+2)'(IMAGE_SIZE))
                 && (row_full >= 0) && (row_full < (DEND_W+2)'(IMAGE_SIZE));
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= divx_valid && divy_valid;
        end
    end

    // hold the result for its one output cycle
    always_ff @(posedge clk) begin
        valid_reg <= in_img;
        row_reg   <= in_img ? row_full[COORD_W-1:0] : '0;
        col_reg   <= in_img ? col_full[COORD_W-1:0] : '0;
    end

    assign done      = done_reg;
    assign src_valid = valid_reg;
    assign src_row   = row_reg;
    assign src_col   = col_reg;

    `PLW_ASSERT_IMPLY(a_latency, start, ##LATENCY done, "result missing after fixed latency")
    `PLW_ASSERT_IMPLY(a_zero_invalid, done && !src_valid, (src_row == '0) && (src_col == '0), "invalid result carries an address")
    `PLW_ASSERT_IMPLY(a_offset_nonzero, done && src_valid, lens_offset_reg != '0, "valid result with zero lens offset")
    `PLW_ASSERT_NEXT(a_cfg_lens, cfg_valid && (cfg_index == REG_LENS_OFFSET), lens_offset_reg == $signed($past(cfg_data)), "lens offset write lost")

endmodule

>>> tb/sv/point_lens_warp_address_top_tb.sv
// Testbench for the point lens warp address generator: directed and random pixels
module point_lens_warp_address_top_tb;
    import plw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one expected source address
    typedef struct {
        logic               ok;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } src_addr_t;

    // Predicts source addresses and compares the returned ones in order
    class warp_scoreboard;
        longint          lens_r;
        longint          ein_e;
        src_addr_t       pending[$];
        int              mismatches;

        function void reset_regs();
            lens_r = 1;
            ein_e  = 1;
        endfunction

        function void write_reg(logic idx, logic [CFG_W-1:0] data);
            if (idx == REG_LENS_OFFSET)
                lens_r = longint'($signed(data[LENS_W-1:0]));
            else
                ein_e = longint'(data[EIN_W-1:0]);
        endfunction

        // quotient rounded half away from zero
        function longint round_div(longint num, longint den);
            longint n;
            longint d;
            n = num;
            d = den;
            if (d < 0)
            begin
                d = -d;
                n = -n;
            end
            if (n >= 0)
                return (2 * n + d) / (2 * d);
            return -((2 * (-n) + d) / (2 * d));
        endfunction

        // work out the source of one destination pixel and queue it
        function void note_pixel(logic [COORD_W-1:0] out_r, logic [COORD_W-1:0] out_c);
            src_addr_t exp_a;
            longint x, y, d, q, e2, sx, sy, sr, sc;
            exp_a = '{ok: 1'b0, row: '0, col: '0};
            e2 = ein_e * ein_e;
            x  = longint'(out_c) - HALF - lens_r;
            y  = HALF - longint'(out_r);
            d  = (x + lens_r) * (x + lens_r) + y * y;
            if (lens_r != 0 && d != 0 && out_r < IMAGE_SIZE && out_c < IMAGE_SIZE)
            begin
                q  = lens_r * d;
                sx = round_div(x * q + e2 * (x * x + y * y + lens_r * x), q);
                sy = round_div(y * d - e2 * y, d);
                sr = HALF - sy;
                sc = HALF + lens_r + sx;
                if (sr >= 0 && sr < IMAGE_SIZE && sc >= 0 && sc < IMAGE_SIZE)
                    exp_a = '{ok: 1'b1, row: sr[COORD_W-1:0], col: sc[COORD_W-1:0]};
            end
            pending = {pending, exp_a};
        endfunction

        // compare one returned transaction with the oldest expectation
        function void check_src(logic ok, logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
            src_addr_t exp_a;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: valid=%0b row=%0d col=%0d", ok, r, c);
                return;
            end
            exp_a = pending.pop_front();
            if (ok !== exp_a.ok || r !== exp_a.row || c !== exp_a.col)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("bad result: expected valid=%0b row=%0d col=%0d, got %0b %0d %0d",
                             exp_a.ok, exp_a.row, exp_a.col, ok, r, c);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               done;
    logic               src_valid;
    logic [COORD_W-1:0] src_row;
    logic [COORD_W-1:0] src_col;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    warp_scoreboard sb;
    int             n_pixels_taken;
    int             n_cfg_taken;
    int             quiet_cycles;
    int             idle_pct;

    localparam int QUIET_LIMIT = 4000;

    point_lens_warp_address_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .out_row   (out_row),
        .out_col   (out_col),
        .done      (done),
        .src_valid (src_valid),
        .src_row   (src_row),
        .src_col   (src_col),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // watch both channels and the result strobe at each rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles = quiet_cycles + 1;
            if (start && !busy)
            begin
                sb.note_pixel(out_row, out_col);
                n_pixels_taken = n_pixels_taken + 1;
                quiet_cycles = 0;
            end
            if (cfg_valid && cfg_ready)
            begin
                sb.write_reg(cfg_index, cfg_data);
                n_cfg_taken = n_cfg_taken + 1;
                quiet_cycles = 0;
            end
            if (done)
            begin
                sb.check_src(src_valid, src_row, src_col);
                quiet_cycles = 0;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // send one pixel; called at a falling edge, returns at a falling edge with start
    // still high, so the next pixel can follow at once
    task automatic send_pixel(int r, int c);
        int taken;
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        taken = n_pixels_taken;
        start   <= 1'b1;
        out_row <= COORD_W'(r);
        out_col <= COORD_W'(c);
        do @(negedge clk); while (n_pixels_taken == taken);
    endtask

    // write one register; valid stays high on return
    task automatic write_cfg(logic idx, logic [CFG_W-1:0] data);
        int taken;
        taken = n_cfg_taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge clk); while (n_cfg_taken == taken);
    endtask

    // drop start and hold off until every queued result has come back
    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // set both lens registers while the pipeline is empty
    task automatic set_lens(int r, int e);
        logic [CFG_W-1:0] ew;
        drain();
        write_cfg(REG_LENS_OFFSET, CFG_W'(r));
        ew = CFG_W'(e);
        ew[CFG_W-1:EIN_W] = (CFG_W-EIN_W)'($urandom);
        write_cfg(REG_EINSTEIN, ew);
        cfg_valid <= 1'b0;
    endtask

    // random pixels; mostly near the image centre so the warp is exercised
    task automatic random_pixels(int count);
        int c;
        int rr;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(3, 0) == 0)
            begin
                c  = $urandom_range(IMAGE_SIZE - 1, 0);
                rr = $urandom_range(IMAGE_SIZE - 1, 0);
            end
            else
            begin
                c  = HALF + $urandom_range(40, 0) - 20;
                rr = HALF + $urandom_range(40, 0) - 20;
            end
            send_pixel(rr, c);
        end
    endtask

    initial
    begin
        int lr;
        sb = new();
        sb.reset_regs();
        sb.mismatches = 0;
        n_pixels_taken = 0;
        n_cfg_taken = 0;
        quiet_cycles = 0;
        idle_pct = 32;
        rst_n = 1'b0;
        start = 1'b0;
        out_row = '0;
        out_col = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_LENS_OFFSET;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset registers, image corners, lens centre, near centre
        send_pixel(0, 0);
        send_pixel(511, 511);
        send_pixel(0, 511);
        send_pixel(511, 0);
        send_pixel(HALF, HALF);
        send_pixel(HALF, HALF + 1);
        send_pixel(HALF + 1, HALF);
        send_pixel(HALF - 1, HALF - 1);
        // strong lens pushes sources out of the image
        set_lens(1023, 511);
        send_pixel(0, 0);
        send_pixel(HALF, HALF + 3);
        send_pixel(511, 511);
        set_lens(-1023, 0);
        send_pixel(HALF, HALF);
        send_pixel(100, 400);
        // zero offset: every pixel invalid
        set_lens(0, 37);
        send_pixel(HALF, HALF + 5);
        send_pixel(20, 30);
        set_lens(3, 2);
        send_pixel(HALF, HALF);
        send_pixel(HALF - 1, HALF + 1);
        send_pixel(HALF + 2, HALF - 3);

        // random phases; the third runs without sender gaps
        for (int ph = 0; ph < 8; ph++)
        begin
            case ($urandom_range(3, 0))
                0: lr = $urandom_range(2046, 0) - 1023;
                1: lr = $urandom_range(40, 0) - 20;
                default: lr = $urandom_range(200, 0) - 100;
            endcase
            set_lens(lr, ($urandom_range(3, 0) == 0) ? $urandom_range(511, 0)
                                                    : $urandom_range(60, 0));
            idle_pct = (ph == 2) ? 0 : 32;
            random_pixels(210);
        end

        drain();
        repeat (LATENCY + 4) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/plw_pkg.sv
hw/rtl/plw_front.sv
hw/rtl/plw_div.sv
hw/rtl/point_lens_warp_address_top.sv
tb/sv/point_lens_warp_address_top_tb.sv
